FILE: design/mfts_pkg.sv
// ----------------------------------------------------------------------------
// mfts_pkg
// shared types and constants of the multilevel feedback thread scheduler
// ----------------------------------------------------------------------------
package mfts_pkg;

  // slot and level geometry
  localparam int MAX_THREADS = 16;
  localparam int NUM_LEVELS  = 6;

  // field widths
  localparam int ID_W    = 4;
  localparam int LVL_W   = 3;
  localparam int OP_W    = 2;
  localparam int FILL_W  = $clog2(MAX_THREADS + 1);
  localparam int QDEPTH  = NUM_LEVELS * MAX_THREADS;
  localparam int QADDR_W = $clog2(QDEPTH);

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(NUM_LEVELS - 1);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_PREEMPT = 2'd1,
    OP_EXIT    = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [LVL_W-1:0] level;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0] new_id;
    logic            create_ok;
    logic [ID_W-1:0] running_id;
    logic            running_valid;
    logic            switched;
    logic            halted;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DISP,
    ST_LOAD,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;
    logic exec;
    logic disp;
    logic load;
    logic publish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic need_disp;
  } stat_t;

endpackage

FILE: design/mfts_ram.sv
// ----------------------------------------------------------------------------
// mfts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mfts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mfts_ctrl.sv
// ----------------------------------------------------------------------------
// mfts_ctrl
// sequencing state machine and output register valid for the scheduler
// ----------------------------------------------------------------------------
module mfts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  mfts_pkg::stat_t stat,
  output mfts_pkg::cmd_t  cmd
);

  import mfts_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = stat.need_disp ? ST_DISP : ST_DONE;
      end
      ST_DISP: state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.latch = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_DISP: cmd.disp = 1'b1;
      ST_LOAD: cmd.load = 1'b1;
      ST_DONE: cmd.publish = out_free;
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = cmd.publish || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: design/mfts_dp.sv
// ----------------------------------------------------------------------------
// mfts_dp
// scheduler datapath: slot map, level queues, running thread, result register
// ----------------------------------------------------------------------------
module mfts_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  mfts_pkg::cmd_t      cmd,
  output mfts_pkg::stat_t     stat,
  input  mfts_pkg::in_item_t  in_item,
  output mfts_pkg::out_item_t out_item
);

  import mfts_pkg::*;

  // control state
  logic [MAX_THREADS-1:0] slot_map_r;
  logic [ID_W-1:0]        head_r [NUM_LEVELS];
  logic [FILL_W-1:0]      fill_r [NUM_LEVELS];
  logic [ID_W-1:0]        cur_r;
  logic                   cur_valid_r;
  logic [FILL_W-1:0]      live_r;
  logic                   halt_r;

  // payload state
  logic [LVL_W-1:0] tlevel_r [MAX_THREADS];
  in_item_t         item_r;
  logic [ID_W-1:0]  new_id_r;
  logic             ok_r;
  logic             sw_r;
  logic             hit_r;
  out_item_t        res_r;

  // decode of the held transaction
  logic is_create, is_pre, is_exit;
  logic free_found;
  logic [ID_W-1:0] free_idx;
  logic [LVL_W-1:0] lvl_sat, cur_lvl, demote_lvl, push_lv;
  logic [ID_W-1:0] push_id, push_pos;
  logic [FILL_W:0] push_sum;
  logic push_en;
  logic disp_found;
  logic [LVL_W-1:0] disp_lv;
  logic [ID_W-1:0] disp_head;
  logic [QADDR_W-1:0] waddr, raddr;
  logic [ID_W-1:0] rdata;

  assign is_create = !halt_r && (item_r.opcode == OP_CREATE);
  assign is_pre    = !halt_r && (item_r.opcode == OP_PREEMPT);
  assign is_exit   = !halt_r && (item_r.opcode == OP_EXIT) && cur_valid_r;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (!slot_map_r[i]) begin
        free_found = 1'b1;
        free_idx   = ID_W'(i);
      end
    end
  end

  assign lvl_sat    = (item_r.level > LVL_MAX) ? LVL_MAX : item_r.level;
  assign cur_lvl    = tlevel_r[cur_r];
  assign demote_lvl = (cur_lvl >= LVL_MAX) ? LVL_MAX : cur_lvl + 1'b1;

  assign push_lv  = is_create ? lvl_sat : demote_lvl;
  assign push_id  = is_create ? free_idx : cur_r;
  assign push_sum = {1'b0, FILL_W'(head_r[push_lv])} + {1'b0, fill_r[push_lv]};
  assign push_pos = (push_sum >= (FILL_W+1)'(MAX_THREADS))
                  ? ID_W'(push_sum - (FILL_W+1)'(MAX_THREADS)) : ID_W'(push_sum);
  assign push_en  = cmd.exec && ((is_create && free_found) || (is_pre && cur_valid_r))
                  && (fill_r[push_lv] < FILL_W'(MAX_THREADS));
  assign waddr    = QADDR_W'(int'(push_lv) * MAX_THREADS + int'(push_pos));

  assign stat.need_disp = is_pre || (is_exit && (cur_r != '0));

  // highest nonempty level
  always_comb begin
    disp_found = 1'b0;
    disp_lv    = '0;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if (fill_r[l] != '0) begin
        disp_found = 1'b1;
        disp_lv    = LVL_W'(l);
      end
    end
  end

  assign disp_head = head_r[disp_lv];
  assign raddr     = QADDR_W'(int'(disp_lv) * MAX_THREADS + int'(disp_head));

  mfts_ram #(
    .WIDTH (ID_W),
    .DEPTH (QDEPTH)
  ) u_queue_ram (
    .clk   (clk),
    .we    (push_en),
    .waddr (waddr),
    .wdata (push_id),
    .re    (cmd.disp && disp_found),
    .raddr (raddr),
    .rdata (rdata)
  );

  // control state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_map_r  <= '0;
      cur_r       <= '0;
      cur_valid_r <= 1'b0;
      live_r      <= '0;
      halt_r      <= 1'b0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        head_r[l] <= '0;
        fill_r[l] <= '0;
      end
    end else begin
      if (push_en) begin
        fill_r[push_lv] <= fill_r[push_lv] + 1'b1;
      end
      if (cmd.exec && is_create && free_found) begin
        slot_map_r[free_idx] <= 1'b1;
        live_r <= live_r + 1'b1;
      end
      if (cmd.exec && is_exit) begin
        if (cur_r == '0) begin
          halt_r      <= 1'b1;
          cur_valid_r <= 1'b0;
          cur_r       <= '0;
        end else begin
          // the exiting thread stops running until the dispatch loads another
          slot_map_r[cur_r] <= 1'b0;
          cur_valid_r       <= 1'b0;
          if (live_r != '0) begin
            live_r <= live_r - 1'b1;
          end
        end
      end
      if (cmd.disp) begin
        if (disp_found) begin
          head_r[disp_lv] <= (disp_head == ID_W'(MAX_THREADS - 1))
                           ? '0 : disp_head + 1'b1;
          fill_r[disp_lv] <= fill_r[disp_lv] - 1'b1;
        end else begin
          cur_valid_r <= 1'b0;
          cur_r       <= '0;
        end
      end
      if (cmd.load && hit_r) begin
        cur_r       <= rdata;
        cur_valid_r <= 1'b1;
      end
    end
  end

  // payload updates
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
    if (cmd.exec) begin
      new_id_r <= (is_create && free_found) ? free_idx : '0;
      ok_r     <= is_create && free_found;
      sw_r     <= 1'b0;
      if (is_create && free_found) begin
        tlevel_r[free_idx] <= lvl_sat;
      end
      if (is_pre && cur_valid_r) begin
        tlevel_r[cur_r] <= demote_lvl;
      end
    end
    if (cmd.disp) begin
      hit_r <= disp_found;
      sw_r  <= disp_found;
    end
    if (cmd.publish) begin
      res_r.new_id        <= new_id_r;
      res_r.create_ok     <= ok_r;
      res_r.running_id    <= cur_valid_r ? cur_r : '0;
      res_r.running_valid <= cur_valid_r;
      res_r.switched      <= sw_r;
      res_r.halted        <= halt_r;
    end
  end

  assign out_item = res_r;

  // live count tracks the slot map
  a_live_count: assert property (@(posedge clk) disable iff (!rst_n)
    int'(live_r) == $countones(slot_map_r))
    else $error("live thread count disagrees with slot map");

  // a running thread always owns its slot
  a_running_owned: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> slot_map_r[cur_r])
    else $error("running thread has a free slot");

  // nothing runs once halted
  a_halt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !cur_valid_r)
    else $error("thread running after halt");

endmodule

FILE: design/multilevel_feedback_thread_scheduler.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_thread_scheduler
// hardware thread scheduler with multilevel feedback ready queues
// ----------------------------------------------------------------------------
// usage
//   in channel: in_valid / in_stall carry one command transaction (create,
//   preempt, exit) with a starting level for create
//   out channel: out_valid / out_stall carry one result transaction per
//   command: new slot id, create status, running thread and flags
// sequencing
//   create, exit of thread 0 and ignored commands go from execute straight
//   to publish; preempt and exit with dispatch add a dispatch read and a
//   dispatch load, the registered read of the queue ram at the head of the
//   chosen level
//   one command at a time: the next one is taken only after the previous
//   one has been published
// reset
//   rst_n low clears the slot map, queue heads and fills, running thread
//   and halt flag; queue ram and thread levels are written before use
// back pressure
//   a finished result sits in the output register while out_stall is high;
//   the next command is still accepted and worked on, and waits only at
//   its final step for the output register to drain
// ----------------------------------------------------------------------------
module multilevel_feedback_thread_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mfts_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mfts_pkg::out_item_t out_item
);

  import mfts_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencing: idle, execute, dispatch read, dispatch load, publish
  mfts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // slot map, level queues and result register
  mfts_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

FILE: tb/sv/multilevel_feedback_thread_scheduler_test.sv
// ----------------------------------------------------------------------------
// multilevel_feedback_thread_scheduler_test
// self-checking bench: a shadow scheduler inside a small scoreboard class
// predicts every result transaction from the accepted commands, while random
// idling on the command side and random stalls on the result side exercise
// the handshakes; a directed opening, random phases with shifting command
// mixes, and a closing sequence that drains the threads and halts the block
// ----------------------------------------------------------------------------
module multilevel_feedback_thread_scheduler_test;
  import mfts_pkg::*;

  // opcode with no command behind it, the block ignores it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int IDLE_PCT     = 34;
  localparam int RANDOM_ITEMS = 2000;
  localparam int QUIET_FIRST  = 800;   // stretch with no idling on either side
  localparam int QUIET_LAST   = 1200;
  localparam int HANG_LIMIT   = 4000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 20;    // well past the dispatch path

  // --------------------------------------------------------------------------
  // shadow scheduler and store of predicted result transactions
  // --------------------------------------------------------------------------
  class sched_shadow;
    logic [MAX_THREADS-1:0] slot_map;
    logic [ID_W-1:0]        ready_q [NUM_LEVELS][MAX_THREADS];
    logic [ID_W-1:0]        q_head [NUM_LEVELS];
    logic [FILL_W-1:0]      q_fill [NUM_LEVELS];
    logic [LVL_W-1:0]       thr_level [MAX_THREADS];
    logic [ID_W-1:0]        run_id;
    logic                   run_valid;
    int                     live_cnt;
    logic                   halt_seen;
    out_item_t              pending_results[$];
    int                     mismatches;

    function new();
      slot_map   = '0;
      run_id     = '0;
      run_valid  = 1'b0;
      live_cnt   = 0;
      halt_seen  = 1'b0;
      mismatches = 0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        q_head[l] = '0;
        q_fill[l] = '0;
      end
    endfunction

    // append a thread at the tail of a level, a full level drops it
    function void enqueue(logic [LVL_W-1:0] lv, logic [ID_W-1:0] id);
      int pos;
      if (q_fill[lv] >= MAX_THREADS) return;
      pos = (int'(q_head[lv]) + int'(q_fill[lv])) % MAX_THREADS;
      ready_q[lv][pos] = id;
      q_fill[lv]++;
    endfunction

    // head of the highest nonempty level becomes the running thread
    function logic dispatch();
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (q_fill[l] != 0) begin
          run_id    = ready_q[l][q_head[l]];
          run_valid = 1'b1;
          q_head[l] = q_head[l] + 1'b1;
          q_fill[l]--;
          return 1'b1;
        end
      end
      run_valid = 1'b0;
      run_id    = '0;
      return 1'b0;
    endfunction

    // advance the shadow state by one accepted command, queue its result
    function void note_command(in_item_t cmd);
      out_item_t        res;
      logic [LVL_W-1:0] lv;
      res = '0;
      if (!halt_seen) begin
        case (cmd.opcode)
          OP_CREATE: begin
            lv = (cmd.level > LVL_MAX) ? LVL_MAX : cmd.level;
            for (int i = 0; i < MAX_THREADS; i++) begin
              if (!slot_map[i] && !res.create_ok) begin
                slot_map[i]   = 1'b1;
                thr_level[i]  = lv;
                enqueue(lv, ID_W'(i));
                live_cnt++;
                res.new_id    = ID_W'(i);
                res.create_ok = 1'b1;
              end
            end
          end
          OP_PREEMPT: begin
            // demote by one level, saturating at the lowest
            if (run_valid) begin
              lv = thr_level[run_id];
              lv = (lv >= LVL_MAX) ? LVL_MAX : lv + 3'd1;
              thr_level[run_id] = lv;
              enqueue(lv, run_id);
            end
            res.switched = dispatch();
          end
          OP_EXIT: begin
            if (run_valid) begin
              if (run_id == '0) begin
                // thread 0 leaving stops the scheduler, slot stays taken
                halt_seen = 1'b1;
                run_valid = 1'b0;
                run_id    = '0;
              end else begin
                slot_map[run_id] = 1'b0;
                if (live_cnt != 0) live_cnt--;
                res.switched = dispatch();
              end
            end
          end
          default: begin
          end
        endcase
      end
      res.running_id    = run_valid ? run_id : '0;
      res.running_valid = run_valid;
      res.halted        = halt_seen;
      pending_results.insert(pending_results.size(), res);
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %p",
                 $time, got);
        mismatches++;
        return;
      end
      want = pending_results[0];
      pending_results.delete(0);
      if (got.new_id !== want.new_id || got.create_ok !== want.create_ok ||
          got.running_id !== want.running_id ||
          got.running_valid !== want.running_valid ||
          got.switched !== want.switched || got.halted !== want.halted) begin
        $display("%0t: result mismatch, expected %p", $time, want);
        $display("%0t:                  actual   %p", $time, got);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;

  sched_shadow sched;
  logic        no_idle;
  int          hang_cnt;

  multilevel_feedback_thread_scheduler u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk       = 1'b0;
    out_stall = 1'b0;
    no_idle   = 1'b0;
    hang_cnt  = 0;
  end

  always #5 clk = ~clk;

  // result side back pressure, changed only at the falling edge
  always @(negedge clk) begin
    out_stall = !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  // result monitor and hang watchdog, both sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sched.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        hang_cnt = 0;
      end else begin
        hang_cnt++;
      end
      if (hang_cnt >= HANG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, HANG_LIMIT);
        $display("** multilevel_feedback_thread_scheduler: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // command driver: one transaction, with an optional idle gap in front
  // the shadow state moves on at the accepting edge, so the caller can pick
  // the next command from the up-to-date running thread
  // --------------------------------------------------------------------------
  task automatic send_command(input logic [OP_W-1:0] op, input logic [LVL_W-1:0] lv);
    in_item_t cmd;
    int       gap;
    cmd.opcode = op;
    cmd.level  = lv;
    gap = (!no_idle && $urandom_range(99) < IDLE_PCT) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = cmd;
    do @(posedge clk); while (in_stall);
    sched.note_command(cmd);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int              mix;
    int              pick;
    int              guard;
    logic [OP_W-1:0] op;

    sched    = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed opening on an empty scheduler
    send_command(OP_EXIT, 3'd0);      // exit with nothing running, ignored
    send_command(OP_UNUSED, 3'd7);    // unused opcode, ignored
    send_command(OP_PREEMPT, 3'd0);   // nothing ready, no switch
    send_command(OP_CREATE, 3'd7);    // out of range level saturates
    send_command(OP_CREATE, 3'd6);
    for (int l = 0; l < NUM_LEVELS; l++) send_command(OP_CREATE, LVL_W'(l));
    send_command(OP_PREEMPT, 3'd0);   // preempt with no running thread dispatches
    send_command(OP_PREEMPT, 3'd0);   // demote and pick another
    send_command(OP_EXIT, 3'd0);      // exit frees slot and dispatches
    send_command(OP_CREATE, 3'd0);    // freed slot is reused
    send_command(OP_PREEMPT, 3'd5);

    // random phases, each with its own command mix: create heavy phases
    // fill the slot map, exit heavy phases empty it again
    mix = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) mix = $urandom_range(2);
      no_idle = (n >= QUIET_FIRST && n < QUIET_LAST);
      pick = $urandom_range(99);
      case (mix)
        0:       op = (pick < 65) ? OP_CREATE : (pick < 90) ? OP_PREEMPT :
                      (pick < 97) ? OP_EXIT : OP_UNUSED;
        1:       op = (pick < 35) ? OP_CREATE : (pick < 70) ? OP_PREEMPT :
                      (pick < 95) ? OP_EXIT : OP_UNUSED;
        default: op = (pick < 10) ? OP_CREATE : (pick < 50) ? OP_PREEMPT :
                      (pick < 95) ? OP_EXIT : OP_UNUSED;
      endcase
      // thread 0 leaving would halt the block, keep that for the end
      if (op == OP_EXIT && sched.run_valid && sched.run_id == '0) op = OP_PREEMPT;
      send_command(op, LVL_W'($urandom_range(7)));
    end
    no_idle = 1'b0;

    // closing: retire every other thread until thread 0 runs alone
    guard = 0;
    while ((sched.live_cnt > 1 || !sched.run_valid || sched.run_id != '0) &&
           guard < 500) begin
      if (sched.run_valid && sched.run_id != '0) begin
        send_command(OP_EXIT, 3'd0);
      end else begin
        send_command(OP_PREEMPT, 3'd0);
      end
      guard++;
    end
    send_command(OP_PREEMPT, 3'd0);   // empty queues: requeued and redispatched
    send_command(OP_EXIT, 3'd0);      // thread 0 exits, block halts
    send_command(OP_CREATE, 3'd2);    // everything after halt is ignored
    send_command(OP_PREEMPT, 3'd0);
    send_command(OP_EXIT, 3'd0);
    send_command(OP_UNUSED, 3'd1);

    @(negedge clk);
    in_valid = 1'b0;

    // drain, then give stray results a chance to show up
    while (sched.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sched.mismatches == 0 && sched.pending_results.size() == 0) begin
      $display("** multilevel_feedback_thread_scheduler: PASSED **");
    end else begin
      $display("** multilevel_feedback_thread_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
